// File: design/pts_pkg.sv
// Package for the periodic task slot scheduler.
// Holds item structs, decoded command and result codes, and state encodings.
// Used by pts_front, pts_back and periodic_task_slot_scheduler_unit.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;

  localparam int unsigned SlotsDefault  = 20;
  localparam int unsigned ChecksDefault = 5;
  localparam logic [31:0] GapReset      = 32'd10;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned ChunkW        = 8;

  localparam logic [2:0] OpTick    = 3'd0;
  localparam logic [2:0] OpCreate  = 3'd1;
  localparam logic [2:0] OpSetIv   = 3'd2;
  localparam logic [2:0] OpPause   = 3'd3;
  localparam logic [2:0] OpRun     = 3'd4;
  localparam logic [2:0] OpRead    = 3'd5;

  typedef enum logic [2:0] {
    K_DUE     = 3'd0,
    K_CREATED = 3'd1,
    K_NOFREE  = 3'd2,
    K_DONE    = 3'd3,
    K_READ    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_CREATE,
    CMD_SET_IV,
    CMD_PAUSE,
    CMD_RUN,
    CMD_READ,
    CMD_NOP
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_EX,
    ST_TICK_FIN,
    ST_FIND,
    ST_SLOT_RW
  } st_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  slot_index;
    logic [31:0] period_ms;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [4:0]  result_slot;
    logic [31:0] elapsed_value;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    cmd_e        kind;
    logic        ok;
    logic [4:0]  idx;
    logic [31:0] period;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [31:0] last_run;
    logic [31:0] period;
    logic [31:0] elapsed;
  } row_t;

endpackage
`default_nettype wire

// File: design/pts_front.sv
// Front end: takes items, decodes operation and range-checks the slot index,
// and queues decoded commands for the back end. Depends on pts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pts_front import pts_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire in_item_t cmd_i,
  output logic          busy,
  input  wire logic     pop_i,
  output logic          head_valid_o,
  output cmd_t          head_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            q_mem [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  cmd_t            dec;
  logic            push, pop;

  always_comb begin
    dec.idx    = cmd_i.slot_index;
    dec.period = cmd_i.period_ms;
    dec.now    = cmd_i.now_ms;
    dec.ok     = 32'(cmd_i.slot_index) < 32'(SLOTS);
    unique case (cmd_i.operation)
      OpTick:   dec.kind = CMD_TICK;
      OpCreate: dec.kind = CMD_CREATE;
      OpSetIv:  dec.kind = CMD_SET_IV;
      OpPause:  dec.kind = CMD_PAUSE;
      OpRun:    dec.kind = CMD_RUN;
      OpRead:   dec.kind = CMD_READ;
      default:  dec.kind = CMD_NOP;
    endcase
  end

  assign busy         = cnt_q == CntW'(QueueDepth);
  assign push         = start && !busy;
  assign head_valid_o = cnt_q != '0;
  assign pop          = pop_i && head_valid_o;
  assign head_o       = q_mem[rd_q];

  always_comb begin
    wr_d  = push ? PtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop ? PtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= dec;
    end
  end

endmodule
`default_nettype wire

// File: design/pts_back.sv
// Back end: executes decoded commands against the slot table.
// Slot timing words live in a one-port-read memory with per-slot valid bits.
// Depends on pts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pts_back import pts_pkg::*; #(
  parameter int unsigned SLOTS  = SlotsDefault,
  parameter int unsigned CHECKS = ChecksDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  head_valid_i,
  input  wire cmd_t  head_i,
  output logic       pop_o,
  output logic       res_valid_o,
  output out_item_t  res_o
);

  localparam int unsigned SW     = $clog2(SLOTS);
  localparam int unsigned CntW   = $clog2(CHECKS + 1);
  localparam int unsigned NChunk = (SLOTS + ChunkW - 1) / ChunkW;
  localparam int unsigned ChW    = $clog2(NChunk + 1);
  localparam int unsigned PadW   = NChunk * ChunkW;

  st_e               state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [SW-1:0]     cur_q, cur_d, scan_q, scan_d, scan_nxt, idx_slot, found_slot;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ChW-1:0]    chunk_q, chunk_d;
  logic [31:0]       gap_q, gap_d, lct_q, lct_d;
  logic              pend_v_q, pend_v_d;
  logic [SW-1:0]     pend_slot_q, pend_slot_d;
  logic [31:0]       pend_e_q, pend_e_d;
  logic [SLOTS-1:0]  active_q, active_d, paused_q, paused_d, valid_q, valid_d;
  logic              res_v_q, res_v_d;
  out_item_t         res_q, res_d;

  row_t              mem [SLOTS];
  row_t              rd_q, row, wdata;
  logic              rd_en, mem_we;
  logic [SW-1:0]     rd_addr;

  logic              gap_pass, scan_run, cnt_last, due, found, chunk_last;
  logic [31:0]       elapsed;
  logic [PadW-1:0]   act_pad;
  logic [ChunkW-1:0] chunk_bits;
  logic [2:0]        pos;

  assign idx_slot   = SW'(head_i.idx);
  assign gap_pass   = (head_i.now - lct_q) > gap_q;
  assign scan_run   = active_q[scan_q] && !paused_q[scan_q];
  assign cnt_last   = cnt_q == CntW'(CHECKS - 1);
  assign scan_nxt   = (scan_q == SW'(SLOTS - 1)) ? '0 : SW'(scan_q + 1'b1);
  assign row        = valid_q[cur_q] ? rd_q : '0;
  assign elapsed    = cmd_q.now - row.last_run;
  assign due        = elapsed >= row.period;
  assign chunk_last = chunk_q == ChW'(NChunk - 1);
  assign pop_o      = (state_q == ST_IDLE) && head_valid_i;

  // free-slot search, one chunk of active bits per cycle; pad bits read busy
  always_comb begin
    act_pad = '1;
    act_pad[SLOTS-1:0] = active_q;
    chunk_bits = act_pad[ChunkW*chunk_q +: ChunkW];
    found = !(&chunk_bits);
    pos = '0;
    for (int i = ChunkW - 1; i >= 0; i--) begin
      if (!chunk_bits[i]) begin
        pos = 3'(i);
      end
    end
    found_slot = SW'({chunk_q, pos});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          unique case (head_i.kind)
            CMD_TICK:   state_d = gap_pass ? ST_TICK_RD : ST_IDLE;
            CMD_CREATE: state_d = ST_FIND;
            CMD_SET_IV,
            CMD_READ:   state_d = head_i.ok ? ST_SLOT_RW : ST_IDLE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_TICK_RD: begin
        if (scan_run) begin
          state_d = ST_TICK_EX;
        end else if (cnt_last) begin
          state_d = ST_TICK_FIN;
        end
      end
      ST_TICK_EX:  state_d = cnt_last ? ST_TICK_FIN : ST_TICK_RD;
      ST_TICK_FIN: state_d = ST_IDLE;
      ST_FIND: begin
        if (found) begin
          state_d = ST_SLOT_RW;
        end else if (chunk_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_SLOT_RW:  state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    scan_d      = scan_q;
    cnt_d       = cnt_q;
    chunk_d     = chunk_q;
    gap_d       = gap_q;
    lct_d       = lct_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    pend_e_d    = pend_e_q;
    active_d    = active_q;
    paused_d    = paused_q;
    valid_d     = valid_q;
    res_v_d     = 1'b0;
    res_d       = '0;
    rd_en       = 1'b0;
    rd_addr     = cur_q;
    mem_we      = 1'b0;
    wdata       = row;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          cmd_d    = head_i;
          cur_d    = idx_slot;
          cnt_d    = '0;
          chunk_d  = '0;
          pend_v_d = 1'b0;
          unique case (head_i.kind)
            CMD_TICK: begin
              if (gap_pass) begin
                lct_d = head_i.now;
              end else begin
                res_v_d = 1'b1;
                res_d   = '{K_DONE, 5'd0, 32'd0, 1'b1};
              end
            end
            CMD_CREATE: ;
            CMD_SET_IV: begin
              if (head_i.ok) begin
                rd_en   = 1'b1;
                rd_addr = idx_slot;
                if ((head_i.period >> 2) < gap_q) begin
                  gap_d = head_i.period >> 2;
                end
              end else begin
                res_v_d = 1'b1;
                res_d   = '{K_DONE, head_i.idx, 32'd0, 1'b1};
              end
            end
            CMD_PAUSE,
            CMD_RUN: begin
              if (head_i.ok) begin
                paused_d[idx_slot] = head_i.kind == CMD_PAUSE;
              end
              res_v_d = 1'b1;
              res_d   = '{K_DONE, head_i.idx, 32'd0, 1'b1};
            end
            CMD_READ: begin
              if (head_i.ok) begin
                rd_en   = 1'b1;
                rd_addr = idx_slot;
              end else begin
                res_v_d = 1'b1;
                res_d   = '{K_READ, head_i.idx, 32'd0, 1'b1};
              end
            end
            default: begin
              res_v_d = 1'b1;
              res_d   = '{K_DONE, 5'd0, 32'd0, 1'b1};
            end
          endcase
        end
      end
      ST_TICK_RD: begin
        cur_d = scan_q;
        if (scan_run) begin
          rd_en   = 1'b1;
          rd_addr = scan_q;
        end else begin
          scan_d = scan_nxt;
          cnt_d  = CntW'(cnt_q + 1'b1);
        end
      end
      ST_TICK_EX: begin
        mem_we          = 1'b1;
        valid_d[cur_q]  = 1'b1;
        wdata.elapsed   = elapsed;
        wdata.last_run  = due ? cmd_q.now : row.last_run;
        if (due) begin
          // hold each due slot back one step so the final one can carry last
          if (pend_v_q) begin
            res_v_d = 1'b1;
            res_d   = '{K_DUE, 5'(pend_slot_q), pend_e_q, 1'b0};
          end
          pend_v_d    = 1'b1;
          pend_slot_d = cur_q;
          pend_e_d    = elapsed;
        end
        scan_d = scan_nxt;
        cnt_d  = CntW'(cnt_q + 1'b1);
      end
      ST_TICK_FIN: begin
        res_v_d = 1'b1;
        if (pend_v_q) begin
          res_d = '{K_DUE, 5'(pend_slot_q), pend_e_q, 1'b1};
        end else begin
          res_d = '{K_DONE, 5'd0, 32'd0, 1'b1};
        end
        pend_v_d = 1'b0;
      end
      ST_FIND: begin
        if (found) begin
          active_d[found_slot] = 1'b1;
          cur_d   = found_slot;
          rd_en   = 1'b1;
          rd_addr = found_slot;
        end else begin
          chunk_d = ChW'(chunk_q + 1'b1);
          if (chunk_last) begin
            res_v_d = 1'b1;
            res_d   = '{K_NOFREE, 5'd0, 32'd0, 1'b1};
          end
        end
      end
      ST_SLOT_RW: begin
        res_v_d = 1'b1;
        unique case (cmd_q.kind)
          CMD_CREATE: begin
            mem_we         = 1'b1;
            valid_d[cur_q] = 1'b1;
            wdata.last_run = cmd_q.now;
            wdata.elapsed  = '0;
            res_d = '{K_CREATED, 5'(cur_q), 32'd0, 1'b1};
          end
          CMD_SET_IV: begin
            mem_we         = 1'b1;
            valid_d[cur_q] = 1'b1;
            wdata.period   = cmd_q.period;
            res_d = '{K_DONE, cmd_q.idx, 32'd0, 1'b1};
          end
          CMD_READ: res_d = '{K_READ, cmd_q.idx, row.elapsed, 1'b1};
          default:  res_d = '{K_DONE, 5'd0, 32'd0, 1'b1};
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      scan_q   <= '0;
      cnt_q    <= '0;
      chunk_q  <= '0;
      gap_q    <= GapReset;
      lct_q    <= '0;
      pend_v_q <= 1'b0;
      active_q <= '0;
      paused_q <= '0;
      valid_q  <= '0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      cnt_q    <= cnt_d;
      chunk_q  <= chunk_d;
      gap_q    <= gap_d;
      lct_q    <= lct_d;
      pend_v_q <= pend_v_d;
      active_q <= active_d;
      paused_q <= paused_d;
      valid_q  <= valid_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    cur_q       <= cur_d;
    pend_slot_q <= pend_slot_d;
    pend_e_q    <= pend_e_d;
    res_q       <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cur_q] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// File: design/periodic_task_slot_scheduler_unit.sv
// Periodic task slot scheduler, top level: front end with command queue, back end.
// Tick below gap, pause, run and unknown ops answer from idle; set and read pass through
// a slot read/write state; a full tick checks at most CHECKS slots; create searches 8 slots per chunk.
// The back end holds one item at a time and takes the next only once idle;
// a 2-entry queue takes items meanwhile.
// Reset clears all control state; slot memory reads zero until written via valid bits.
// Results are strobed for one cycle; the receiver cannot stall. Depends on pts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_slot_scheduler_unit import pts_pkg::*; #(
  parameter int unsigned SLOTS  = SlotsDefault,
  parameter int unsigned CHECKS = ChecksDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire in_item_t cmd_i,
  output logic          busy,
  output logic          res_valid_o,
  output out_item_t     res_o
);

  logic head_valid, pop;
  cmd_t head;

  pts_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .busy        (busy),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  pts_back #(
    .SLOTS (SLOTS),
    .CHECKS(CHECKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire
